### hdl/tsol_pkg.sv
// Shared types and codes for the transpose self-organising list.
package tsol_pkg;

  // Command codes carried on in_command
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ACCESS = 2'd2,
    CMD_NOP    = 2'd3
  } tsol_cmd_t;

  // Status codes returned on out_status
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_MOVED = 2'd3
  } tsol_status_t;

  // Controller states
  typedef enum logic {
    FSM_INIT  = 1'b0,
    FSM_READY = 1'b1
  } tsol_state_t;

  // Commands from controller to the cell row
  typedef struct packed {
    logic insert;
    logic swap;
  } tsol_op_t;

  localparam int unsigned FIELD_W = 5;

endpackage

### hdl/transpose_self_organizing_list.sv
// Transpose self-organising list: one command a cycle when not busy, one result beat each.
// A command accepted at one edge gives its result beat (out_valid) in the next cycle.
// Throughput: one command per cycle when not busy; cells compare, then shift or swap.
// busy is high for the first cycle after reset only, then stays low.
// Reset (rst_n low, synchronous) empties the list; entry cells are not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module transpose_self_organizing_list
  import tsol_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic signed [31:0]  in_key_value,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [4:0]          out_match_position,
  output logic [4:0]          out_entry_count
);

  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  tsol_op_t      op;
  logic [CW-1:0] fill_count;
  logic          hit;
  logic [IW-1:0] hit_idx;

  // Command controller
  tsol_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .hit                (hit),
    .hit_idx            (hit_idx),
    .op                 (op),
    .fill_count         (fill_count),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_match_position (out_match_position),
    .out_entry_count    (out_entry_count)
  );

  // Cell row datapath
  tsol_cells #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_cells (
    .clk        (clk),
    .op         (op),
    .key        (in_key_value),
    .fill_count (fill_count),
    .hit        (hit),
    .hit_idx    (hit_idx)
  );

endmodule

### hdl/tsol_cells.sv
// Row of key cells with parallel compare, shift-in and transpose swap.
module tsol_cells
  import tsol_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16,
  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                 clk,
  input  tsol_op_t             op,
  input  logic signed [31:0]   key,
  input  logic [CW-1:0]        fill_count,
  output logic                 hit,
  output logic [IW-1:0]        hit_idx
);

  logic [31:0]           cell_r   [LIST_DEPTH];
  logic [31:0]           cell_nxt [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;
  logic [LIST_DEPTH-1:0] sel;
  logic [LIST_DEPTH-1:0] sel_up;

  // Compare every held entry below the head against the key
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match[i] = (i != 0) && (CW'(i) < fill_count) && (cell_r[i] == key);
    end
  end

  // Keep only the first match from the head
  assign sel    = match & (~match + LIST_DEPTH'(1));
  assign sel_up = sel >> 1;
  assign hit    = |match;

  // Encode the one-hot selection into an index
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (sel[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Shift in at the head, or swap the selected entry with its predecessor
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (op.insert) begin
        cell_nxt[i] = (i == 0) ? key : cell_r[(i == 0) ? 0 : i - 1];
      end else if (op.swap) begin
        if (sel[i]) begin
          cell_nxt[i] = cell_r[(i == 0) ? 0 : i - 1];
        end else if (sel_up[i]) begin
          cell_nxt[i] = key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

endmodule

### hdl/tsol_ctrl.sv
// Command controller: fill count, decode, status and result registers.
module tsol_ctrl
  import tsol_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16,
  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic                 hit,
  input  logic [IW-1:0]        hit_idx,
  output tsol_op_t             op,
  output logic [CW-1:0]        fill_count,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [FIELD_W-1:0]   out_match_position,
  output logic [FIELD_W-1:0]   out_entry_count
);

  tsol_state_t        state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               valid_r;
  tsol_status_t       status_r, status_nxt;
  logic [FIELD_W-1:0] pos_r, pos_nxt;
  logic [FIELD_W-1:0] cnt_out_r;
  logic               accept;
  tsol_cmd_t          cmd;

  assign cmd    = tsol_cmd_t'(in_command);
  assign accept = start && !busy;

  // State register and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_INIT;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      cnt_out_r <= FIELD_W'(count_nxt);
    end
  end

  // Next state, command decode and status
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    pos_nxt    = '0;
    op         = '0;
    busy       = 1'b0;
    case (state_r)
      FSM_INIT: begin
        busy      = 1'b1;
        state_nxt = FSM_READY;
      end
      FSM_READY: begin
        if (start) begin
          case (cmd)
            CMD_INSERT: begin
              if (count_r == CW'(LIST_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                op.insert = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_ACCESS: begin
              if (count_r < CW'(2)) begin
                status_nxt = ST_EMPTY;
              end else if (hit) begin
                op.swap = 1'b1;
                pos_nxt = FIELD_W'(hit_idx);
              end else begin
                status_nxt = ST_NOT_MOVED;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = FSM_INIT;
      end
    endcase
  end

  assign fill_count         = count_r;
  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_match_position = pos_r;
  assign out_entry_count    = cnt_out_r;

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("fill count above depth");

  // One result beat follows every accepted command
  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result beat missing");

  // A swap needs at least two entries held
  a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
    op.swap |-> (count_r >= CW'(2)))
    else $error("swap with short list");

  // Insert and swap never fire together
  a_op_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.insert && op.swap))
    else $error("insert and swap together");

endmodule
